@@ rtl/least_squares_slope_fit_assert.svh @@
// Assertion macros for the checker file of the slope fit block.
`ifndef LEAST_SQUARES_SLOPE_FIT_ASSERT_SVH
`define LEAST_SQUARES_SLOPE_FIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSSF_ASSERT_SAME(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LSSF_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

@@ rtl/lssf_pkg.sv @@
// Package of the slope fit block: sizes, state codes and control structs.
package lssf_pkg;

	// Field formats.
	localparam int ROW_BITS         = 6;
	localparam int COLUMN_BITS      = 8;
	localparam int MAX_POINTS       = 64;
	localparam int FRAC_BITS        = 16;
	localparam int SLOPE_BITS       = 25;
	localparam int POINT_COUNT_BITS = 7;

	// Accumulator sizes follow from the window length and the point format.
	localparam int ROW_MAX  = (1 << ROW_BITS) - 1;
	localparam int COL_MAX  = (1 << COLUMN_BITS) - 1;
	localparam int CNT_BITS = $clog2(MAX_POINTS + 1);
	localparam int SX_BITS  = $clog2(MAX_POINTS * ROW_MAX + 1);
	localparam int SY_BITS  = $clog2(MAX_POINTS * COL_MAX + 1);
	localparam int SXX_BITS = $clog2(MAX_POINTS * ROW_MAX * ROW_MAX + 1);
	localparam int SXY_BITS = $clog2(MAX_POINTS * ROW_MAX * COL_MAX + 1);

	// Shared multiplier operand and product widths.
	localparam int MUL_A_BITS = (SX_BITS > CNT_BITS) ? SX_BITS : CNT_BITS;
	localparam int MUL_B_0    = (SXY_BITS > SY_BITS) ? SXY_BITS : SY_BITS;
	localparam int MUL_B_1    = (SXX_BITS > SX_BITS) ? SXX_BITS : SX_BITS;
	localparam int MUL_B_BITS = (MUL_B_0 > MUL_B_1) ? MUL_B_0 : MUL_B_1;
	localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

	// Width that holds every product term, numerator and denominator.
	localparam int PA_BITS   = CNT_BITS + SXY_BITS;
	localparam int PB_BITS   = SX_BITS + SY_BITS;
	localparam int PC_BITS   = CNT_BITS + SXX_BITS;
	localparam int PD_BITS   = 2 * SX_BITS;
	localparam int W_0       = (PA_BITS > PB_BITS) ? PA_BITS : PB_BITS;
	localparam int W_1       = (PC_BITS > PD_BITS) ? PC_BITS : PD_BITS;
	localparam int WIDE_BITS = (W_0 > W_1) ? W_0 : W_1;

	// Restoring divider sizes.
	localparam int DIV_BITS     = WIDE_BITS + FRAC_BITS;
	localparam int REM_BITS     = WIDE_BITS + 1;
	localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

	// Saturation limits of the slope magnitude.
	localparam longint SLOPE_POS_MAX = (longint'(1) << (SLOPE_BITS - 1)) - 1;
	localparam longint SLOPE_NEG_MAX = longint'(1) << (SLOPE_BITS - 1);

	typedef logic [ROW_BITS-1:0]           row_t;
	typedef logic [COLUMN_BITS-1:0]        column_t;
	typedef logic signed [SLOPE_BITS-1:0]  slope_t;
	typedef logic [POINT_COUNT_BITS-1:0]   point_count_t;

	typedef enum logic [3:0] {
		ST_ACCUM,
		ST_MUL_NSXY,
		ST_MUL_SXSY,
		ST_MUL_NSXX,
		ST_MUL_SXSX,
		ST_SETUP,
		ST_DIVIDE,
		ST_FINISH
	} lssf_state_t;

	typedef enum logic [1:0] {
		MUL_N_SXY,
		MUL_SX_SY,
		MUL_N_SXX,
		MUL_SX_SX
	} mul_sel_t;

	typedef struct packed {
		logic     accum;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     setup;
		logic     div_step;
		logic     load_out;
	} lssf_cmd_t;

	typedef struct packed {
		logic degen;
	} lssf_status_t;

endpackage

@@ rtl/lssf_if.sv @@
// Handshake channels of the slope fit block: input points and fit results.
interface lssf_point_if;
	import lssf_pkg::*;

	logic    valid;
	logic    ready;
	row_t    row_index;
	column_t column_value;
	logic    last_point;

	modport source(output valid, row_index, column_value, last_point, input ready);
	modport sink(input valid, row_index, column_value, last_point, output ready);
endinterface

interface lssf_fit_if;
	import lssf_pkg::*;

	logic         valid;
	logic         ready;
	slope_t       slope;
	logic         degenerate;
	point_count_t point_count;

	modport source(output valid, slope, degenerate, point_count, input ready);
	modport sink(input valid, slope, degenerate, point_count, output ready);
endinterface

@@ rtl/lssf_ctrl.sv @@
// Sequencer of the slope fit block: accumulation, products, division, result.
module lssf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_last,
	output logic                  in_ready,
	input  logic                  out_ready,
	output logic                  out_valid,
	input  lssf_pkg::lssf_status_t status,
	output lssf_pkg::lssf_cmd_t   cmd
);
	import lssf_pkg::*;

	localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIV_BITS - 1);

	lssf_state_t             state_q, state_d;
	logic [DIV_CNT_BITS-1:0] div_cnt_q;
	logic                    out_valid_q;
	logic                    out_free;

	// A finished result may be written when the output register is empty or draining.
	assign out_free = !out_valid_q || out_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_ACCUM: begin
				if (in_valid && in_last) state_d = ST_MUL_NSXY;
			end
			ST_MUL_NSXY: state_d = ST_MUL_SXSY;
			ST_MUL_SXSY: state_d = ST_MUL_NSXX;
			ST_MUL_NSXX: state_d = ST_MUL_SXSX;
			ST_MUL_SXSX: state_d = ST_SETUP;
			ST_SETUP:    state_d = ST_DIVIDE;
			ST_DIVIDE: begin
				if (status.degen || div_cnt_q == DIV_LAST) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_ACCUM;
			end
			default: state_d = ST_ACCUM;
		endcase
	end

	// Datapath commands and the input handshake.
	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = MUL_N_SXY;
		in_ready     = 1'b0;
		unique case (state_q)
			ST_ACCUM: begin
				in_ready  = 1'b1;
				cmd.accum = in_valid;
			end
			ST_MUL_NSXY: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_N_SXY;
			end
			ST_MUL_SXSY: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SX_SY;
			end
			ST_MUL_NSXX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_N_SXX;
			end
			ST_MUL_SXSX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SX_SX;
			end
			ST_SETUP:  cmd.setup    = 1'b1;
			ST_DIVIDE: cmd.div_step = !status.degen;
			ST_FINISH: cmd.load_out = out_free;
			default: ;
		endcase
	end

	// State register and division step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_ACCUM;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIVIDE) div_cnt_q <= div_cnt_q + 1'b1;
			else div_cnt_q <= '0;
		end
	end

	// Output valid flag: set on a new result, cleared when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/lssf_datapath.sv @@
// Datapath of the slope fit block: sums, shared multiplier, divider, result register.
module lssf_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lssf_pkg::lssf_cmd_t    cmd,
	input  lssf_pkg::row_t         row_index,
	input  lssf_pkg::column_t      column_value,
	output lssf_pkg::lssf_status_t status,
	output lssf_pkg::slope_t       slope,
	output logic                   degenerate,
	output lssf_pkg::point_count_t point_count
);
	import lssf_pkg::*;

	localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_POINTS);
	localparam logic [DIV_BITS-1:0] POS_MAX = DIV_BITS'(SLOPE_POS_MAX);
	localparam logic [DIV_BITS-1:0] NEG_MAX = DIV_BITS'(SLOPE_NEG_MAX);

	logic [CNT_BITS-1:0]   cnt_q;
	logic [SX_BITS-1:0]    sx_q;
	logic [SY_BITS-1:0]    sy_q;
	logic [SXX_BITS-1:0]   sxx_q;
	logic [SXY_BITS-1:0]   sxy_q;

	logic [MUL_A_BITS-1:0] op_a;
	logic [MUL_B_BITS-1:0] op_b;
	logic [MUL_P_BITS-1:0] product;
	logic [WIDE_BITS-1:0]  prod_nsxy_q, prod_sxsy_q, prod_nsxx_q, prod_sxsx_q;

	logic                  degen_q;
	logic                  neg_q;
	logic [WIDE_BITS-1:0]  den_q;
	logic [WIDE_BITS-1:0]  rem_q;
	logic [DIV_BITS-1:0]   quot_q;
	logic [REM_BITS-1:0]   rem_shift;
	logic [REM_BITS-1:0]   rem_diff;
	logic                  q_bit;

	logic [DIV_BITS-1:0]   mag_sat;
	logic [SLOPE_BITS-1:0] slope_bits;

	slope_t                slope_q;
	logic                  degen_out_q;
	point_count_t          count_out_q;

	// Window sums: one point per beat until the window is full, cleared with each result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxx_q <= '0;
			sxy_q <= '0;
		end else if (cmd.load_out) begin
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxx_q <= '0;
			sxy_q <= '0;
		end else if (cmd.accum && cnt_q < CNT_MAX) begin
			cnt_q <= cnt_q + 1'b1;
			sx_q  <= sx_q + SX_BITS'(row_index);
			sy_q  <= sy_q + SY_BITS'(column_value);
			sxx_q <= sxx_q + SXX_BITS'(row_index) * SXX_BITS'(row_index);
			sxy_q <= sxy_q + SXY_BITS'(row_index) * SXY_BITS'(column_value);
		end
	end

	// Shared multiplier operand selection.
	always_comb begin
		unique case (cmd.mul_sel)
			MUL_N_SXY: begin
				op_a = MUL_A_BITS'(cnt_q);
				op_b = MUL_B_BITS'(sxy_q);
			end
			MUL_SX_SY: begin
				op_a = MUL_A_BITS'(sx_q);
				op_b = MUL_B_BITS'(sy_q);
			end
			MUL_N_SXX: begin
				op_a = MUL_A_BITS'(cnt_q);
				op_b = MUL_B_BITS'(sxx_q);
			end
			MUL_SX_SX: begin
				op_a = MUL_A_BITS'(sx_q);
				op_b = MUL_B_BITS'(sx_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign product = MUL_P_BITS'(op_a) * MUL_P_BITS'(op_b);

	// Product registers, one written per multiply cycle.
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				MUL_N_SXY: prod_nsxy_q <= WIDE_BITS'(product);
				MUL_SX_SY: prod_sxsy_q <= WIDE_BITS'(product);
				MUL_N_SXX: prod_nsxx_q <= WIDE_BITS'(product);
				MUL_SX_SX: prod_sxsx_q <= WIDE_BITS'(product);
				default: ;
			endcase
		end
	end

	// Restoring division step: one quotient bit per cycle.
	assign rem_shift = {rem_q, quot_q[DIV_BITS-1]};
	assign rem_diff  = rem_shift - {1'b0, den_q};
	assign q_bit     = (rem_shift >= {1'b0, den_q});

	// Divider setup, then the iteration.
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			degen_q <= (prod_nsxx_q <= prod_sxsx_q);
			den_q   <= prod_nsxx_q - prod_sxsx_q;
			neg_q   <= (prod_nsxy_q < prod_sxsy_q);
			rem_q   <= '0;
			if (prod_nsxy_q >= prod_sxsy_q) begin
				quot_q <= {prod_nsxy_q - prod_sxsy_q, FRAC_BITS'(0)};
			end else begin
				quot_q <= {prod_sxsy_q - prod_nsxy_q, FRAC_BITS'(0)};
			end
		end else if (cmd.div_step) begin
			rem_q  <= q_bit ? rem_diff[WIDE_BITS-1:0] : rem_shift[WIDE_BITS-1:0];
			quot_q <= {quot_q[DIV_BITS-2:0], q_bit};
		end
	end

	assign status.degen = degen_q;

	// Saturate the quotient, apply the sign and zero the slope of a degenerate fit.
	always_comb begin
		if (neg_q) begin
			mag_sat    = (quot_q > NEG_MAX) ? NEG_MAX : quot_q;
			slope_bits = SLOPE_BITS'(0) - mag_sat[SLOPE_BITS-1:0];
		end else begin
			mag_sat    = (quot_q > POS_MAX) ? POS_MAX : quot_q;
			slope_bits = mag_sat[SLOPE_BITS-1:0];
		end
		if (degen_q) slope_bits = '0;
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			slope_q     <= slope_t'(slope_bits);
			degen_out_q <= degen_q;
			count_out_q <= point_count_t'(cnt_q);
		end
	end

	assign slope       = slope_q;
	assign degenerate  = degen_out_q;
	assign point_count = count_out_q;

endmodule

@@ rtl/least_squares_slope_fit.sv @@
// Top level of the streaming least-squares slope fit block.
//
// Points arrive on the point channel (row_index as x, column_value as y,
// last_point closing a window); each accepted beat is added to the sums.
// Up to MAX_POINTS points are summed; later points of the same window are
// dropped. The beat with last_point set starts the fit: four products on
// the shared multiplier, a setup step, the restoring divider (43 quotient
// bits) and the load of the result register. When the denominator is zero
// the division ends early (degenerate set, slope 0). During the fit the
// point channel is not ready; between windows it is ready in every cycle.
// The result register holds a beat while the receiver stalls and the next
// window is summed meanwhile; a new fit waits in its finish state until the
// register is free. Reset clears all sums and the sequencer and empties
// the result register.
module least_squares_slope_fit (
	input logic         clk,
	input logic         arst_n,
	lssf_point_if.sink  point,
	lssf_fit_if.source  fit
);
	import lssf_pkg::*;

	lssf_cmd_t    cmd;
	lssf_status_t status;

	lssf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (point.valid),
		.in_last   (point.last_point),
		.in_ready  (point.ready),
		.out_ready (fit.ready),
		.out_valid (fit.valid),
		.status    (status),
		.cmd       (cmd)
	);

	lssf_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.row_index    (point.row_index),
		.column_value (point.column_value),
		.status       (status),
		.slope        (fit.slope),
		.degenerate   (fit.degenerate),
		.point_count  (fit.point_count)
	);

endmodule

@@ rtl/lssf_checker.sv @@
// Port-level checker of the slope fit block and its bind to the top level.
`include "least_squares_slope_fit_assert.svh"

module lssf_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   in_last,
	input logic                   out_valid,
	input logic                   out_ready,
	input lssf_pkg::slope_t       slope,
	input logic                   degenerate,
	input lssf_pkg::point_count_t point_count
);
	import lssf_pkg::*;

	localparam point_count_t COUNT_MAX = point_count_t'(MAX_POINTS);
	localparam point_count_t COUNT_ONE = point_count_t'(1);

	// A stalled result beat holds.
	`LSSF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(slope) && $stable(degenerate) && $stable(point_count))

	// The beat that closes a window stops intake while the fit runs.
	`LSSF_ASSERT_NEXT(a_fit_blocks_input, clk, arst_n, in_valid && in_ready && in_last, !in_ready)

	// A degenerate fit carries a zero slope.
	`LSSF_ASSERT_SAME(a_degen_zero, clk, arst_n, out_valid && degenerate, slope == '0)

	// A result counts at least one point and no more than a full window.
	`LSSF_ASSERT_SAME(a_count_range, clk, arst_n, out_valid, point_count != '0 && point_count <= COUNT_MAX)

	// A single point cannot define a slope.
	`LSSF_ASSERT_SAME(a_single_degen, clk, arst_n, out_valid && point_count == COUNT_ONE, degenerate)

endmodule

bind least_squares_slope_fit lssf_checker u_lssf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (point.valid),
	.in_ready    (point.ready),
	.in_last     (point.last_point),
	.out_valid   (fit.valid),
	.out_ready   (fit.ready),
	.slope       (fit.slope),
	.degenerate  (fit.degenerate),
	.point_count (fit.point_count)
);

@@ tb/sv/tb_least_squares_slope_fit.sv @@
// Self-checking testbench of the least-squares slope fit block.
module tb_least_squares_slope_fit;
	timeunit 1ns;
	timeprecision 1ps;

	import lssf_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 60;
	localparam int PHASE_POINTS   = 175;
	localparam int PROBE_ROWS     = 17;

	// One fit result as it appears on the fit channel.
	typedef struct packed {
		slope_t       slope;
		logic         degenerate;
		point_count_t point_count;
	} fit_t;

	// One row of the directed stimulus; typed rows carry their own answer.
	typedef struct {
		int     row;
		int     col;
		bit     last;
		bit     typed;
		longint t_slope;
		bit     t_degen;
		int     t_count;
	} probe_t;

	bit   clk;
	logic arst_n;

	lssf_point_if point();
	lssf_fit_if   fit();

	least_squares_slope_fit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.point  (point.sink),
		.fit    (fit.source)
	);

	// Free-running clock, 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Running sums of the window being collected, as the block should hold them.
	logic [6:0]  pts_held;
	logic [11:0] row_sum;
	logic [13:0] col_sum;
	logic [17:0] row_sq_sum;
	logic [19:0] row_col_sum;

	fit_t expected_fits[$];
	int   mismatch_count;
	int   idle_cycles;
	int   send_idle_pct;
	int   recv_stall_pct;

	// Answer typed into the directed table for the beat now on the bus.
	logic beat_typed;
	fit_t beat_typed_fit;

	probe_t probe_tab [0:PROBE_ROWS-1];

	// Least-squares slope of the points held, truncated and saturated to Q9.16.
	function automatic fit_t predict_fit();
		longint n, sxy, sx, sy, sxx;
		longint num_a, num_b, den_c, den_d, den, mag;
		logic   neg;
		fit_t   f;
		n   = pts_held;
		sx  = row_sum;
		sy  = col_sum;
		sxx = row_sq_sum;
		sxy = row_col_sum;
		num_a = n * sxy;
		num_b = sx * sy;
		den_c = n * sxx;
		den_d = sx * sx;
		f.point_count = pts_held;
		f.degenerate  = (den_c <= den_d);
		f.slope       = '0;
		if (!f.degenerate) begin
			den = den_c - den_d;
			neg = (num_a < num_b);
			mag = neg ? (num_b - num_a) : (num_a - num_b);
			mag = (mag << FRAC_BITS) / den;
			if (neg) begin
				if (mag > SLOPE_NEG_MAX)
					mag = SLOPE_NEG_MAX;
				f.slope = slope_t'(-mag);
			end else begin
				if (mag > SLOPE_POS_MAX)
					mag = SLOPE_POS_MAX;
				f.slope = slope_t'(mag);
			end
		end
		return f;
	endfunction

	task automatic report_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Track accepted beats on both channels and compare each result in order.
	always @(posedge clk) begin : scoreboard
		fit_t want;
		if (arst_n) begin
			if (point.valid && point.ready) begin
				if (pts_held < MAX_POINTS) begin
					pts_held    = pts_held + 7'd1;
					row_sum     = row_sum + 12'(point.row_index);
					col_sum     = col_sum + 14'(point.column_value);
					row_sq_sum  = row_sq_sum + 18'(point.row_index) * 18'(point.row_index);
					row_col_sum = row_col_sum + 20'(point.row_index) * 20'(point.column_value);
				end
				if (point.last_point) begin
					want = predict_fit();
					if (beat_typed)
						want = beat_typed_fit;
					expected_fits.push_back(want);
					pts_held    = '0;
					row_sum     = '0;
					col_sum     = '0;
					row_sq_sum  = '0;
					row_col_sum = '0;
				end
			end
			if (fit.valid && fit.ready) begin
				if (expected_fits.size() == 0) begin
					$display("%0t ns: unexpected fit beat, expected none, got slope %0d",
						$time, fit.slope);
					mismatch_count++;
				end else begin
					want = expected_fits.pop_front();
					report_field("slope", want.slope, fit.slope);
					report_field("degenerate", want.degenerate, fit.degenerate);
					report_field("point_count", want.point_count, fit.point_count);
				end
			end
			if ((point.valid && point.ready) || (fit.valid && fit.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	// Receiver stalls at the rate of the current phase.
	initial begin
		fit.ready = 1'b0;
		forever begin
			@(negedge clk);
			fit.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	// Drive one beat from a falling edge and hold it until it is accepted.
	task automatic send_point(input row_t r, input column_t c, input logic l,
			input logic typed, input fit_t tfit);
		while ($urandom_range(99) < send_idle_pct) begin
			point.valid <= 1'b0;
			@(negedge clk);
		end
		point.valid        <= 1'b1;
		point.row_index    <= r;
		point.column_value <= c;
		point.last_point   <= l;
		beat_typed         <= typed;
		beat_typed_fit     <= tfit;
		@(posedge clk);
		while (!point.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// One random window: a noisy line, scattered points or a single row.
	task automatic send_window(output int held);
		int len, mode, r0, dr, c0, dc;
		row_t    r;
		column_t c;
		len = $urandom_range(99);
		if (len < 4)
			len = $urandom_range(70, 64);
		else if (len < 12)
			len = 1;
		else
			len = $urandom_range(16, 2);
		mode = $urandom_range(9);
		r0   = $urandom_range(63);
		dr   = $urandom_range(3, 1);
		c0   = $urandom_range(255);
		dc   = int'($urandom_range(16)) - 8;
		for (int i = 0; i < len; i++) begin
			if (mode < 2) begin
				r = row_t'($urandom_range(63));
				c = column_t'($urandom_range(255));
			end else if (mode == 2) begin
				r = row_t'(r0);
				c = column_t'($urandom_range(255));
			end else begin
				r = row_t'(r0 + i * dr);
				c = column_t'(c0 + i * dc + int'($urandom_range(4)) - 2);
			end
			send_point(r, c, i == len - 1, 1'b0, '0);
		end
		held = (len > MAX_POINTS) ? MAX_POINTS : len;
	endtask

	// Main sequence: reset, directed table, then random windows per idle phase.
	initial begin : stimulus
		int   held, phase_pts;
		fit_t tfit;
		arst_n             = 1'b0;
		point.valid        = 1'b0;
		point.row_index    = '0;
		point.column_value = '0;
		point.last_point   = 1'b0;
		beat_typed         = 1'b0;
		beat_typed_fit     = '0;
		pts_held           = '0;
		row_sum            = '0;
		col_sum            = '0;
		row_sq_sum         = '0;
		row_col_sum        = '0;
		mismatch_count     = 0;
		idle_cycles        = 0;
		send_idle_pct      = 0;
		recv_stall_pct     = 0;

		// Directed cases: lone points, steepest slopes, one shared row, plain lines.
		probe_tab = '{
			'{5, 100, 1, 1, 0, 1, 1},
			'{0, 0, 1, 1, 0, 1, 1},
			'{0, 0, 0, 0, 0, 0, 0},
			'{63, 255, 1, 0, 0, 0, 0},
			'{0, 0, 0, 0, 0, 0, 0},
			'{1, 255, 1, 1, 16711680, 0, 2},
			'{0, 255, 0, 0, 0, 0, 0},
			'{1, 0, 1, 1, -16711680, 0, 2},
			'{63, 0, 0, 0, 0, 0, 0},
			'{63, 255, 0, 0, 0, 0, 0},
			'{63, 17, 1, 1, 0, 1, 3},
			'{0, 255, 0, 0, 0, 0, 0},
			'{63, 0, 1, 0, 0, 0, 0},
			'{10, 20, 0, 0, 0, 0, 0},
			'{20, 40, 0, 0, 0, 0, 0},
			'{30, 60, 0, 0, 0, 0, 0},
			'{41, 83, 1, 0, 0, 0, 0}
		};

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (probe_tab[i]) begin
			tfit.slope       = slope_t'(probe_tab[i].t_slope);
			tfit.degenerate  = probe_tab[i].t_degen;
			tfit.point_count = point_count_t'(probe_tab[i].t_count);
			send_point(row_t'(probe_tab[i].row), column_t'(probe_tab[i].col),
				probe_tab[i].last, probe_tab[i].typed, tfit);
		end

		// Random windows under each idle pattern in turn.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
				default: begin send_idle_pct = 38; recv_stall_pct = 38; end
			endcase
			phase_pts = 0;
			while (phase_pts < PHASE_POINTS) begin
				send_window(held);
				phase_pts += held;
			end
		end
		point.valid <= 1'b0;

		// Drain the outstanding results, then watch for stray beats.
		while (expected_fits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/lssf_pkg.sv
rtl/lssf_if.sv
rtl/lssf_ctrl.sv
rtl/lssf_datapath.sv
rtl/least_squares_slope_fit.sv
rtl/lssf_checker.sv
tb/sv/tb_least_squares_slope_fit.sv
